// ===== hdl/i2cram_pkg.sv =====
`default_nettype none
package i2cram_pkg;

	localparam int MAX_BURST = 16;
	localparam int BL_W      = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
	localparam int QDEPTH    = 2;
	localparam int QA_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CFG_IDX_W = 2;

	// host opcodes
	localparam logic [2:0] OPC_TICK   = 3'd0;
	localparam logic [2:0] OPC_READ   = 3'd1;
	localparam logic [2:0] OPC_WRITE  = 3'd2;
	localparam logic [2:0] OPC_BURST  = 3'd3;
	localparam logic [2:0] OPC_VERIFY = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS      = CFG_IDX_W'(1);

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NACK     = 2'd1;
	localparam logic [1:0] ERR_MISMATCH = 2'd2;

	// sequencer program entry points
	localparam logic [4:0] PC_IDLE   = 5'd0;
	localparam logic [4:0] PC_WRITE  = 5'd1;
	localparam logic [4:0] PC_VERIFY = 5'd6;
	localparam logic [4:0] PC_READ   = 5'd11;
	localparam logic [4:0] PC_FINAL  = 5'd18;

	typedef enum logic [2:0] {
		OP_START,
		OP_STOP,
		OP_STOPEND,
		OP_WA,
		OP_RA,
		OP_WREG,
		OP_WVAL,
		OP_RD
	} op_t;

	// one classified word travelling from front to back
	typedef struct packed {
		logic            is_cmd;
		logic [2:0]      opcode;
		logic [7:0]      reg_addr;
		logic [7:0]      wr_val;
		logic [BL_W-1:0] burst_m1;
		logic            sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drive;
		logic       busy;
		logic [7:0] rd_byte;
		logic       rd_valid;
		logic       last;
		logic       done;
		logic [1:0] err;
	} result_t;

	function automatic op_t prog_op(input logic [4:0] pc);
		op_t op;
		unique case (pc)
			5'd1, 5'd6, 5'd11, 5'd15: op = OP_START;
			5'd2, 5'd7, 5'd12:        op = OP_WA;
			5'd3, 5'd8, 5'd13:        op = OP_WREG;
			5'd4, 5'd9:               op = OP_WVAL;
			5'd10, 5'd14:             op = OP_STOP;
			5'd16:                    op = OP_RA;
			5'd17:                    op = OP_RD;
			default:                  op = OP_STOPEND;
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/i2cram_front.sv =====
`default_nettype none
module i2cram_front (
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [23:0]          s_axis_tdata,
	input  wire logic [2:0]           s_axis_tuser,
	input  wire logic                 q_ready,
	output logic                      q_push,
	output i2cram_pkg::item_t         q_item
);

	logic [4:0] bc;
	logic [5:0] n;

	assign s_axis_tready = q_ready;
	assign q_push        = s_axis_tvalid & q_ready;
	assign bc            = s_axis_tdata[20:16];

	// clamp burst length to 1..MAX_BURST
	always_comb begin
		n = (bc == 5'd0) ? 6'd1 : {1'b0, bc};
		if (n > 6'(i2cram_pkg::MAX_BURST)) begin
			n = 6'(i2cram_pkg::MAX_BURST);
		end
	end

	always_comb begin
		q_item.is_cmd     = (s_axis_tuser == i2cram_pkg::OPC_READ)
			|| (s_axis_tuser == i2cram_pkg::OPC_WRITE)
			|| (s_axis_tuser == i2cram_pkg::OPC_BURST)
			|| (s_axis_tuser == i2cram_pkg::OPC_VERIFY);
		q_item.opcode     = s_axis_tuser;
		q_item.reg_addr   = s_axis_tdata[7:0];
		q_item.wr_val     = s_axis_tdata[15:8];
		q_item.burst_m1   = i2cram_pkg::BL_W'(n - 6'd1);
		q_item.sda_sample = s_axis_tdata[21];
	end

endmodule
`default_nettype wire

// ===== hdl/i2cram_queue.sv =====
`default_nettype none
module i2cram_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire i2cram_pkg::item_t push_item,
	output logic                   ready,
	input  wire logic              pop,
	output logic                   valid,
	output i2cram_pkg::item_t      pop_item
);

	i2cram_pkg::item_t               entry_q [i2cram_pkg::QDEPTH];
	logic [i2cram_pkg::QA_W-1:0]     wr_ptr_q;
	logic [i2cram_pkg::QA_W-1:0]     rd_ptr_q;
	logic [i2cram_pkg::QA_W:0]       count_q;

	assign ready    = (count_q != (i2cram_pkg::QA_W+1)'(i2cram_pkg::QDEPTH));
	assign valid    = (count_q != '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == i2cram_pkg::QA_W'(i2cram_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == i2cram_pkg::QA_W'(i2cram_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/i2cram_back.sv =====
`default_nettype none
module i2cram_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [i2cram_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                       cfg_data,
	input  wire logic                             item_valid,
	input  wire i2cram_pkg::item_t                item,
	output logic                                  item_pop,
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output i2cram_pkg::result_t                   res
);

	logic [6:0] slave_addr_q;
	logic [7:0] ticks_q;

	logic [4:0]                  step_q,   n_step;
	logic [1:0]                  sub_q,    n_sub;
	logic [3:0]                  bit_q,    n_bit;
	logic [7:0]                  shift_q,  n_shift;
	logic [i2cram_pkg::BL_W-1:0] left_q,   n_left;
	logic [7:0]                  wait_q,   n_wait;
	logic [2:0]                  cmd_q,    n_cmd;
	logic [7:0]                  reg_q,    n_reg;
	logic [7:0]                  val_q,    n_val;
	logic [1:0]                  perr_q,   n_perr;
	logic                        scl_q,    n_scl;
	logic                        sda_q,    n_sda;
	logic                        drive_q,  n_drive;
	logic                        enter;
	logic [7:0]                  rd_shift;
	i2cram_pkg::op_t             op;
	i2cram_pkg::op_t             n_op;
	i2cram_pkg::result_t         n_res;
	i2cram_pkg::result_t         res_q;
	logic                        res_valid_q;

	assign item_pop  = item_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign op        = i2cram_pkg::prog_op(step_q);
	assign rd_shift  = {shift_q[6:0], item.sda_sample};

	always_comb begin
		n_step  = step_q;
		n_sub   = sub_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_left  = left_q;
		n_wait  = wait_q;
		n_cmd   = cmd_q;
		n_reg   = reg_q;
		n_val   = val_q;
		n_perr  = perr_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_drive = drive_q;
		enter   = 1'b0;
		n_res   = '0;

		if (step_q == i2cram_pkg::PC_IDLE) begin
			if (item.is_cmd) begin
				n_cmd  = item.opcode;
				n_reg  = item.reg_addr;
				n_val  = item.wr_val;
				n_left = (item.opcode == i2cram_pkg::OPC_BURST) ? item.burst_m1 : '0;
				n_perr = i2cram_pkg::ERR_NONE;
				n_wait = '0;
				if (item.opcode == i2cram_pkg::OPC_WRITE) begin
					n_step = i2cram_pkg::PC_WRITE;
				end else if (item.opcode == i2cram_pkg::OPC_VERIFY) begin
					n_step = i2cram_pkg::PC_VERIFY;
				end else begin
					n_step = i2cram_pkg::PC_READ;
				end
				enter = 1'b1;
			end
		end else if (wait_q != '0) begin
			n_wait = wait_q - 1'b1;
		end else begin
			unique case (op)
				i2cram_pkg::OP_START: begin
					if (sub_q == 2'd0) begin
						n_sda = 1'b0; n_drive = 1'b1; n_sub = 2'd1;
					end else begin
						n_scl = 1'b0; n_step = step_q + 1'b1; enter = 1'b1;
					end
				end
				i2cram_pkg::OP_STOP, i2cram_pkg::OP_STOPEND: begin
					if (sub_q == 2'd0) begin
						n_sda = 1'b0; n_drive = 1'b1; n_sub = 2'd1;
					end else if (sub_q == 2'd1) begin
						n_scl = 1'b1; n_sub = 2'd2;
					end else begin
						n_sda = 1'b1;
						if (op == i2cram_pkg::OP_STOPEND) begin
							n_res.done = 1'b1;
							n_res.err  = perr_q;
							n_perr     = i2cram_pkg::ERR_NONE;
							n_step     = i2cram_pkg::PC_IDLE;
							n_sub      = 2'd0;
							n_bit      = 4'd0;
						end else begin
							n_step = step_q + 1'b1; enter = 1'b1;
						end
					end
				end
				i2cram_pkg::OP_RD: begin
					if (bit_q < 4'd8) begin
						if (sub_q == 2'd0) begin
							n_drive = 1'b0; n_scl = 1'b1; n_sub = 2'd1;
						end else begin
							n_shift = rd_shift;
							n_scl   = 1'b0;
							n_bit   = bit_q + 1'b1;
							n_sub   = 2'd0;
							if (bit_q == 4'd7) begin
								n_res.rd_valid = 1'b1;
								n_res.rd_byte  = rd_shift;
								n_res.last     = (left_q == '0);
								if ((left_q == '0) && (cmd_q == i2cram_pkg::OPC_VERIFY)
									&& (rd_shift != val_q)) begin
									n_perr = i2cram_pkg::ERR_MISMATCH;
								end
							end
						end
					end else begin
						if (sub_q == 2'd0) begin
							// ACK every byte but the last, which gets a NACK
							n_drive = 1'b1; n_sda = (left_q == '0); n_sub = 2'd1;
						end else if (sub_q == 2'd1) begin
							n_scl = 1'b1; n_sub = 2'd2;
						end else begin
							n_scl = 1'b0;
							if (left_q != '0) begin
								n_left = left_q - 1'b1; enter = 1'b1;
							end else begin
								n_step = step_q + 1'b1; enter = 1'b1;
							end
						end
					end
				end
				default: begin
					if (bit_q < 4'd8) begin
						if (sub_q == 2'd0) begin
							n_sda = shift_q[7]; n_drive = 1'b1; n_sub = 2'd1;
						end else if (sub_q == 2'd1) begin
							n_scl = 1'b1; n_sub = 2'd2;
						end else begin
							n_scl   = 1'b0;
							n_shift = {shift_q[6:0], 1'b0};
							n_bit   = bit_q + 1'b1;
							n_sub   = 2'd0;
						end
					end else begin
						if (sub_q == 2'd0) begin
							n_sda = 1'b0; n_drive = 1'b1; n_sub = 2'd1;
						end else if (sub_q == 2'd1) begin
							n_drive = 1'b0; n_scl = 1'b1; n_sub = 2'd2;
						end else begin
							n_drive = 1'b1;
							n_scl   = 1'b0;
							if (item.sda_sample) begin
								// slave NACK: jump to the closing stop
								n_perr = i2cram_pkg::ERR_NACK;
								n_step = i2cram_pkg::PC_FINAL;
							end else begin
								n_step = step_q + 1'b1;
							end
							enter = 1'b1;
						end
					end
				end
			endcase
			n_wait = ((n_step != i2cram_pkg::PC_IDLE) && (ticks_q != 8'd0))
				? ticks_q - 8'd1 : 8'd0;
		end

		n_op = i2cram_pkg::prog_op(n_step);

		// entering a program step: reset bit counters and load its byte
		if (enter) begin
			n_sub = 2'd0;
			n_bit = 4'd0;
			unique case (n_op)
				i2cram_pkg::OP_WA:   n_shift = {slave_addr_q, 1'b0};
				i2cram_pkg::OP_RA:   n_shift = {slave_addr_q, 1'b1};
				i2cram_pkg::OP_WREG: n_shift = n_reg;
				i2cram_pkg::OP_WVAL: n_shift = n_val;
				default:             n_shift = 8'd0;
			endcase
		end

		n_res.scl   = n_scl;
		n_res.sda   = n_sda;
		n_res.drive = n_drive;
		n_res.busy  = (n_step != i2cram_pkg::PC_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 7'h18;
			ticks_q      <= 8'd1;
			step_q       <= i2cram_pkg::PC_IDLE;
			sub_q        <= '0;
			bit_q        <= '0;
			shift_q      <= '0;
			left_q       <= '0;
			wait_q       <= '0;
			cmd_q        <= '0;
			reg_q        <= '0;
			val_q        <= '0;
			perr_q       <= i2cram_pkg::ERR_NONE;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			drive_q      <= 1'b1;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					i2cram_pkg::CFG_SLAVE_ADDR: slave_addr_q <= cfg_data[6:0];
					i2cram_pkg::CFG_TICKS:      ticks_q      <= cfg_data;
					default: ;
				endcase
			end
			if (item_pop) begin
				step_q  <= n_step;
				sub_q   <= n_sub;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				left_q  <= n_left;
				wait_q  <= n_wait;
				cmd_q   <= n_cmd;
				reg_q   <= n_reg;
				val_q   <= n_val;
				perr_q  <= n_perr;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				drive_q <= n_drive;
				res_q   <= n_res;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/i2c_register_access_master_top.sv =====
// An accepted word is stored in the queue, then the back end registers its result word.
// One word per clock sustained while the result side does not stall; a tick or command enters every cycle.
// The bus sequencer in the back end updates once per word, set by its step logic.
// Reset (arst_n low, asynchronous): idle, SCL 1, SDA 1 driven, queue and output empty,
// slave address 0x18, ticks per phase 1.
`default_nettype none
module i2c_register_access_master_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration writes
	input  wire logic                             cfg_we,
	input  wire logic [i2cram_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                       cfg_data,
	// input words
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// register_address[7:0], write_value[15:8], burst_count[20:16], sda_sample[21],
	// zero fill [23:22]
	input  wire logic [23:0]                      s_axis_tdata,
	// opcode[2:0]
	input  wire logic [2:0]                       s_axis_tuser,
	// result words
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// scl_level[0], sda_level[1], sda_drive[2], busy_res[3], read_byte[11:4],
	// read_valid[12], done_res[13], error_code[15:14]
	output logic [15:0]                           m_axis_tdata,
	// last_byte
	output logic                                  m_axis_tlast
);

	i2cram_pkg::item_t   push_item;
	i2cram_pkg::item_t   pop_item;
	i2cram_pkg::result_t res;
	logic                q_ready;
	logic                q_push;
	logic                q_valid;
	logic                q_pop;

	// Front end: classify each word as tick or command, clamp the burst length.
	i2cram_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_ready       (q_ready),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	// Two-word queue: decouple input acceptance from output stalls.
	i2cram_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	// Back end: run the bus program one phase per ticks-per-phase words, hold the result word.
	i2cram_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (q_valid),
		.item       (pop_item),
		.item_pop   (q_pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	// Pack the result word, lowest field first.
	assign m_axis_tdata = {res.err, res.done, res.rd_valid, res.rd_byte,
		res.busy, res.drive, res.sda, res.scl};
	assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// ===== hdl/i2cram_checker.sv =====
`default_nettype none
module i2cram_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// error code only rides with done
	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[15:14] != i2cram_pkg::ERR_NONE) |-> m_axis_tdata[13])
		else $error("error code without done");

	// done leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[3])
		else $error("busy still set on done");

	// last byte flag only with a received byte, and no byte without valid
	a_last_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tlast || (m_axis_tdata[11:4] != 8'd0))
		|-> m_axis_tdata[12])
		else $error("read data without read_valid");

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("result word changed under stall");

endmodule

bind i2c_register_access_master_top i2cram_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/tb_i2c_register_access_master_top.sv =====
`timescale 1ns / 100ps

module tb_i2c_register_access_master_top;
	import i2cram_pkg::*;

	// quiet cycles (nothing accepted on either side) before the run is declared hung
	localparam int QUIET_LIMIT   = 2000;
	// cycles to let pass after the last result, as a margin
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_WORDS  = 80;
	localparam int REPORT_LIMIT  = 10;

	// opcodes the block does not define, and config slots past the last register
	localparam logic [2:0] OPC_UNDEF_LO = 3'd5;
	localparam logic [2:0] OPC_UNDEF_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
	localparam logic [4:0] BURST_FIELD_MAX = 5'd31;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [7:0]           cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata  = '0;
	logic [2:0]           s_axis_tuser  = OPC_TICK;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;
	logic                 m_axis_tlast;

	i2c_register_access_master_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// ------------------------------------------------------------------
	// Bus sequencer mirror: the transaction program, the bus line latches
	// and the handful of counters that walk through it.
	// ------------------------------------------------------------------
	op_t bus_program [0:18] = '{
		OP_STOPEND,
		OP_START, OP_WA, OP_WREG, OP_WVAL, OP_STOPEND,
		OP_START, OP_WA, OP_WREG, OP_WVAL, OP_STOP,
		OP_START, OP_WA, OP_WREG, OP_STOP, OP_START, OP_RA, OP_RD, OP_STOPEND
	};

	logic [6:0] dev_addr;
	logic [7:0] phase_ticks;
	logic [4:0] pc;
	logic [3:0] bit_cnt;
	logic [7:0] shreg;
	logic [4:0] bytes_rem;
	logic [7:0] wait_cnt;
	logic [2:0] cmd_held;
	logic [7:0] reg_held;
	logic [7:0] val_held;
	logic [1:0] sub;
	logic [1:0] err_pending;
	logic       scl_q;
	logic       sda_q;
	logic       drv_q;
	result_t    line_word;

	// bus line states still owed by the block, oldest first
	result_t due_line_states [$];

	int idle_in_pct   = 23;
	int stall_out_pct = 57;
	int words_sent    = 0;
	int words_checked = 0;
	int bad_words     = 0;
	int quiet_cycles  = 0;
	int xfers_done    = 0;
	int xfers_nack    = 0;
	int xfers_mismatch = 0;
	int bytes_in      = 0;

	function automatic void init_model();
		dev_addr    = 7'h18;
		phase_ticks = 8'd1;
		pc          = PC_IDLE;
		bit_cnt     = '0;
		shreg       = '0;
		bytes_rem   = '0;
		wait_cnt    = '0;
		cmd_held    = '0;
		reg_held    = '0;
		val_held    = '0;
		sub         = '0;
		err_pending = ERR_NONE;
		scl_q       = 1'b1;
		sda_q       = 1'b1;
		drv_q       = 1'b1;
	endfunction

	// Load the shift register for the op the program counter now points at.
	function automatic void load_op();
		sub     = '0;
		bit_cnt = '0;
		case (bus_program[pc])
			OP_WA:   shreg = {dev_addr, 1'b0};
			OP_RA:   shreg = {dev_addr, 1'b1};
			OP_WREG: shreg = reg_held;
			OP_WVAL: shreg = val_held;
			default: shreg = '0;
		endcase
	endfunction

	function automatic void next_op();
		pc = pc + 5'd1;
		load_op();
	endfunction

	// Eight data bits MSB first, then the slave's ACK slot.
	function automatic void shift_out_phase(input logic sample);
		if (bit_cnt < 4'd8) begin
			case (sub)
				2'd0: begin sda_q = shreg[7]; drv_q = 1'b1; sub = 2'd1; end
				2'd1: begin scl_q = 1'b1; sub = 2'd2; end
				default: begin
					scl_q   = 1'b0;
					shreg   = {shreg[6:0], 1'b0};
					bit_cnt = bit_cnt + 4'd1;
					sub     = 2'd0;
				end
			endcase
		end else begin
			case (sub)
				2'd0: begin sda_q = 1'b0; drv_q = 1'b1; sub = 2'd1; end
				2'd1: begin drv_q = 1'b0; scl_q = 1'b1; sub = 2'd2; end
				default: begin
					drv_q = 1'b1;
					scl_q = 1'b0;
					// a high level in the ACK slot aborts to the closing stop
					if (sample) begin
						err_pending = ERR_NACK;
						pc          = PC_FINAL;
						load_op();
					end else begin
						next_op();
					end
				end
			endcase
		end
	endfunction

	// Eight bits in from the slave, then the master's ACK (or NACK on the last byte).
	function automatic void shift_in_phase(input logic sample);
		if (bit_cnt < 4'd8) begin
			if (sub == 2'd0) begin
				drv_q = 1'b0;
				scl_q = 1'b1;
				sub   = 2'd1;
			end else begin
				shreg   = {shreg[6:0], sample};
				scl_q   = 1'b0;
				bit_cnt = bit_cnt + 4'd1;
				sub     = 2'd0;
				if (bit_cnt == 4'd8) begin
					line_word.rd_valid = 1'b1;
					line_word.rd_byte  = shreg;
					line_word.last     = (bytes_rem == 5'd0);
					if (line_word.last && cmd_held == OPC_VERIFY && shreg != val_held)
						err_pending = ERR_MISMATCH;
				end
			end
		end else begin
			case (sub)
				2'd0: begin drv_q = 1'b1; sda_q = (bytes_rem == 5'd0); sub = 2'd1; end
				2'd1: begin scl_q = 1'b1; sub = 2'd2; end
				default: begin
					scl_q = 1'b0;
					if (bytes_rem != 5'd0) begin
						bytes_rem = bytes_rem - 5'd1;
						load_op();
					end else begin
						next_op();
					end
				end
			endcase
		end
	endfunction

	function automatic void bus_phase(input logic sample);
		op_t op;
		op = bus_program[pc];
		case (op)
			OP_START: begin
				if (sub == 2'd0) begin
					sda_q = 1'b0;
					drv_q = 1'b1;
					sub   = 2'd1;
				end else begin
					scl_q = 1'b0;
					next_op();
				end
			end
			OP_STOP, OP_STOPEND: begin
				case (sub)
					2'd0: begin sda_q = 1'b0; drv_q = 1'b1; sub = 2'd1; end
					2'd1: begin scl_q = 1'b1; sub = 2'd2; end
					default: begin
						sda_q = 1'b1;
						if (op == OP_STOPEND) begin
							line_word.done = 1'b1;
							line_word.err  = err_pending;
							err_pending    = ERR_NONE;
							pc             = PC_IDLE;
							sub            = '0;
							bit_cnt        = '0;
						end else begin
							next_op();
						end
					end
				endcase
			end
			OP_RD:   shift_in_phase(sample);
			default: shift_out_phase(sample);
		endcase
	endfunction

	// Advance the mirror by one accepted word and return the line state it leaves.
	function automatic result_t predict_line_state(input logic [2:0] opc, input logic [7:0] ra,
			input logic [7:0] wv, input logic [4:0] bc, input logic smp);
		int n;
		line_word = '0;
		if (pc == PC_IDLE) begin
			if (opc >= OPC_READ && opc <= OPC_VERIFY) begin
				n = bc;
				if (n == 0) n = 1;
				if (n > MAX_BURST) n = MAX_BURST;
				cmd_held    = opc;
				reg_held    = ra;
				val_held    = wv;
				bytes_rem   = (opc == OPC_BURST) ? 5'(n - 1) : 5'd0;
				err_pending = ERR_NONE;
				wait_cnt    = '0;
				case (opc)
					OPC_WRITE:  pc = PC_WRITE;
					OPC_VERIFY: pc = PC_VERIFY;
					default:    pc = PC_READ;
				endcase
				load_op();
			end
		end else if (wait_cnt != 8'd0) begin
			wait_cnt = wait_cnt - 8'd1;
		end else begin
			bus_phase(smp);
			wait_cnt = (pc != PC_IDLE && phase_ticks != 8'd0) ? phase_ticks - 8'd1 : 8'd0;
		end
		line_word.scl   = scl_q;
		line_word.sda   = sda_q;
		line_word.drive = drv_q;
		line_word.busy  = (pc != PC_IDLE);
		if (line_word.rd_valid) bytes_in++;
		if (line_word.done) begin
			xfers_done++;
			if (line_word.err == ERR_NACK) xfers_nack++;
			if (line_word.err == ERR_MISMATCH) xfers_mismatch++;
		end
		return line_word;
	endfunction

	// Pick the SDA level the slave shows next: mostly ACK in the ACK slot, and on a
	// verify readback mostly the bits that were written, so commands get deep.
	function automatic logic slave_sda(input int nack_pct, input int match_pct);
		op_t op;
		op = bus_program[pc];
		if (pc != PC_IDLE && bit_cnt == 4'd8 &&
				(op == OP_WA || op == OP_RA || op == OP_WREG || op == OP_WVAL))
			return ($urandom_range(99) < nack_pct);
		if (op == OP_RD && cmd_held == OPC_VERIFY && bit_cnt < 4'd8 &&
				$urandom_range(99) < match_pct)
			return val_held[7 - bit_cnt];
		return 1'($urandom_range(1));
	endfunction

	function automatic string show_word(input result_t w);
		return $sformatf("scl=%0b sda=%0b drv=%0b busy=%0b byte=%02h rv=%0b last=%0b done=%0b err=%0d",
			w.scl, w.sda, w.drive, w.busy, w.rd_byte, w.rd_valid, w.last, w.done, w.err);
	endfunction

	// ------------------------------------------------------------------
	// Clock, result side pacing, checking and the hang watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// stall the result side at the current rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_out_pct);
	end

	// compare each accepted result word against the oldest predicted line state
	always @(posedge clk) begin : check_results
		result_t seen;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.scl      = m_axis_tdata[0];
			seen.sda      = m_axis_tdata[1];
			seen.drive    = m_axis_tdata[2];
			seen.busy     = m_axis_tdata[3];
			seen.rd_byte  = m_axis_tdata[11:4];
			seen.rd_valid = m_axis_tdata[12];
			seen.done     = m_axis_tdata[13];
			seen.err      = m_axis_tdata[15:14];
			seen.last     = m_axis_tlast;
			if (due_line_states.size() == 0) begin
				bad_words++;
				if (bad_words <= REPORT_LIMIT)
					$display("%0t: unexpected result word: %s", $realtime, show_word(seen));
			end else begin
				want = due_line_states.pop_front();
				words_checked++;
				if (seen !== want) begin
					bad_words++;
					if (bad_words <= REPORT_LIMIT) begin
						$display("%0t: result %0d mismatch", $realtime, words_checked);
						$display("  expected %s", show_word(want));
						$display("  actual   %s", show_word(seen));
					end
				end
			end
		end
	end

	// end the run if neither side moves a word for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
				quiet_cycles, due_line_states.size());
			$display("[i2c_register_access_master_top] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one word (with random idle gaps first), hold until it is taken, then predict.
	task automatic send_word(input logic [2:0] opc, input logic [7:0] ra, input logic [7:0] wv,
			input logic [4:0] bc, input logic smp);
		while ($urandom_range(99) < idle_in_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= opc;
		s_axis_tdata  <= {2'b00, smp, bc, wv, ra};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		due_line_states.push_back(predict_line_state(opc, ra, wv, bc, smp));
		words_sent++;
	endtask

	task automatic send_tick(input int nack_pct, input int match_pct);
		send_word(OPC_TICK, 8'($urandom), 8'($urandom), 5'($urandom),
			slave_sda(nack_pct, match_pct));
	endtask

	// Issue a command from idle and tick the bus until it has closed with its stop.
	task automatic run_command(input logic [2:0] opc, input logic [7:0] ra, input logic [7:0] wv,
			input logic [4:0] bc, input int nack_pct, input int match_pct);
		send_word(opc, ra, wv, bc, 1'($urandom_range(1)));
		while (pc != PC_IDLE) send_tick(nack_pct, match_pct);
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (due_line_states.size() != 0);
	endtask

	// Drain, then let the pipeline settle so a register write lands with nothing in flight.
	task automatic quiesce();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SLAVE_ADDR: dev_addr = data[6:0];
			CFG_TICKS:      phase_ticks = data;
			default:        ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Ticks and undefined opcodes while idle leave the lines alone; writes to the
	// spare config slots change nothing.
	task automatic test_idle_behavior();
		logic [2:0] opc;
		send_word(OPC_TICK, 8'h00, 8'h00, 5'd0, 1'b0);
		send_word(OPC_TICK, 8'hFF, 8'hFF, BURST_FIELD_MAX, 1'b1);
		for (opc = OPC_UNDEF_LO; opc != OPC_TICK; opc++)
			send_word(opc, 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom_range(1)));
		quiesce();
		write_reg(CFG_SPARE_A, 8'hFF);
		write_reg(CFG_SPARE_B, 8'h00);
		send_tick(0, 0);
		send_tick(0, 0);
	endtask

	// A plain read, then verified writes: a readback that matches, then one that
	// mostly will not. Plain writes run in the busy-command test.
	task automatic test_single_commands();
		run_command(OPC_READ, 8'h00, 8'h00, 5'd1, 0, 0);
		run_command(OPC_VERIFY, 8'h3C, 8'hA5, 5'd1, 0, 100);
		run_command(OPC_VERIFY, 8'hC3, 8'h5A, 5'd1, 0, 0);
	endtask

	// Burst lengths: zero acts as one, and a count past the maximum saturates.
	task automatic test_burst_lengths();
		run_command(OPC_BURST, 8'h10, 8'h00, 5'd0, 0, 0);
		run_command(OPC_BURST, 8'h40, 8'h00, BURST_FIELD_MAX, 0, 0);
	endtask

	// The slave refuses: on the address byte, and at a random ACK slot.
	task automatic test_slave_nack();
		run_command(OPC_READ, 8'h01, 8'h00, 5'd1, 100, 0);
		run_command(OPC_VERIFY, 8'h02, 8'h77, 5'd1, 30, 100);
	endtask

	// Commands and undefined opcodes arriving mid-transaction act as plain ticks.
	task automatic test_busy_commands();
		logic [2:0] opc;
		send_word(OPC_WRITE, 8'h44, 8'h99, 5'd1, 1'b0);
		for (opc = OPC_READ; opc != OPC_TICK; opc++) begin
			send_word(opc, 8'($urandom), 8'($urandom), 5'($urandom), slave_sda(0, 0));
			send_tick(0, 0);
		end
		while (pc != PC_IDLE) send_tick(0, 0);
	endtask

	// Reprogram address and bus speed while a read is half done: the new address
	// shows on the repeated-start address byte, the new speed from the next phase.
	task automatic test_config_midflight();
		int n;
		send_word(OPC_READ, 8'h55, 8'h00, 5'd1, 1'b0);
		for (n = 0; n < 50; n++) send_tick(0, 0);
		quiesce();
		write_reg(CFG_SLAVE_ADDR, 8'h19);
		write_reg(CFG_TICKS, 8'd2);
		while (pc != PC_IDLE) send_tick(0, 0);
		quiesce();
		write_reg(CFG_TICKS, 8'd1);
	endtask

	// Slowest bus speed for one full phase and its wait, then back to full speed
	// mid-transaction; force a NACK on the address byte to keep it short.
	task automatic test_slow_bus();
		int n;
		quiesce();
		write_reg(CFG_SLAVE_ADDR, 8'h7F);
		write_reg(CFG_TICKS, 8'hFF);
		send_word(OPC_WRITE, 8'hFF, 8'hFF, 5'd1, 1'b0);
		for (n = 0; n < 255; n++) send_tick(100, 0);
		quiesce();
		write_reg(CFG_TICKS, 8'd1);
		while (pc != PC_IDLE) send_tick(100, 0);
		quiesce();
		write_reg(CFG_SLAVE_ADDR, 8'h18);
	endtask

	// Random traffic at one pacing and one register setting: mostly full
	// transactions, with commands while busy, undefined opcodes and the odd NACK.
	task automatic test_random_traffic(input int in_pct, input int out_pct,
			input logic [7:0] addr, input logic [7:0] ticks);
		int n;
		int roll;
		logic [2:0] opc;
		logic [4:0] bc;
		quiesce();
		idle_in_pct   = in_pct;
		stall_out_pct = out_pct;
		write_reg(CFG_SLAVE_ADDR, addr);
		write_reg(CFG_TICKS, ticks);
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(199) == 0) drain_results();
			bc = ($urandom_range(7) == 0) ? 5'($urandom_range(BURST_FIELD_MAX))
				: 5'($urandom_range(4, 1));
			if (pc == PC_IDLE) begin
				roll = $urandom_range(99);
				if (roll < 80)
					opc = 3'($urandom_range(OPC_VERIFY, OPC_READ));
				else if (roll < 90)
					opc = OPC_TICK;
				else
					opc = 3'($urandom_range(OPC_UNDEF_HI, OPC_UNDEF_LO));
			end else begin
				opc = ($urandom_range(49) == 0) ? 3'($urandom_range(OPC_UNDEF_HI, OPC_READ))
					: OPC_TICK;
			end
			send_word(opc, 8'($urandom), 8'($urandom), bc, slave_sda(4, 85));
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		init_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_behavior();
		test_single_commands();
		test_burst_lengths();
		test_slave_nack();
		test_busy_commands();
		test_config_midflight();
		test_slow_bus();
		// swap the pacing between sides, then run flat out
		test_random_traffic(23, 57, 8'h00, 8'd1);
		test_random_traffic(57, 23, 8'h19, 8'd2);
		test_random_traffic(0, 0, 8'h7F, 8'd0);

		// wait out the last results and a few spare cycles for strays
		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		bad_words += due_line_states.size();

		$display("covered %0d words, %0d results checked, %0d mismatches",
			words_sent, words_checked, bad_words);
		$display("%0d transfers closed (%0d on NACK, %0d on bad readback), %0d bytes read",
			xfers_done, xfers_nack, xfers_mismatch, bytes_in);
		if (bad_words == 0)
			$display("[i2c_register_access_master_top] OK");
		else
			$display("[i2c_register_access_master_top] ERROR");
		$finish;
	end

endmodule
